// File: rtl/lru_page_cache_tags_assert.svh
// Assertion macros for the page cache tag engine.
// Each macro expects signals named clock and reset in the enclosing module.
`ifndef LRU_PAGE_CACHE_TAGS_ASSERT_SVH
`define LRU_PAGE_CACHE_TAGS_ASSERT_SVH

`ifndef SYNTH

`define LPCT_ASSERT_SAME(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("lru_page_cache_tags: same-cycle check failed");

`define LPCT_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("lru_page_cache_tags: next-cycle check failed");

`else

`define LPCT_ASSERT_SAME(name, pre, post)

`define LPCT_ASSERT_NEXT(name, pre, post)

`endif

`endif

// File: rtl/lpct_pkg.sv
`default_nettype none

package lpct_pkg;

   localparam int ENTRIES   = 8;
   localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int PAGE_W    = 32;
   localparam int STAMP_W   = 64;
   localparam int ENTRY_W   = STAMP_W + PAGE_W;
   localparam int CFG_CNT_W = 4;
   localparam int SLOT_W    = 3;
   localparam int STATUS_W  = 2;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;
   localparam int RSP_BITS  = STATUS_W + SLOT_W + 1 + PAGE_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [CSR_ADDR_W-1:0] CSR_ENTRIES_IN_USE = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAGE_LIMIT     = 1'd1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_HIT    = 2'd0,
      STATUS_MISS   = 2'd1,
      STATUS_BADARG = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// File: rtl/lru_page_cache_tags.sv
// Tag and LRU replacement engine for a small fully associative page cache.
// Each request beat carries one page number; each response beat reports hit,
// miss-with-fill or bad argument, the slot now holding the page, and the page
// evicted on a miss that replaced a valid entry. Tags and timestamps live in
// one single-port-read RAM, so a lookup reads the active entries one per
// cycle; a rejected page skips the scan, and a lookup cannot complete while
// the previous response still waits on rsp_tready. The fill is committed
// in the cycle the response is loaded, and the next request is accepted
// while that response waits on rsp_tready. Configuration is written through
// csr_we/csr_addr/csr_wdata; the user must write it only while no request
// is in flight, and the block itself does not enforce this.
`default_nettype none

`include "lru_page_cache_tags_assert.svh"

module lru_page_cache_tags (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [lpct_pkg::PAGE_W-1:0]         req_tdata,  // [31:0] page_number
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [1:0] status, [4:2] slot, [5] evicted_valid, [37:6] evicted_page, rest zero
   output logic [lpct_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   input  wire logic                                csr_we,
   input  wire logic [lpct_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  wire logic [lpct_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int IDX_W   = lpct_pkg::IDX_W;
   localparam int CNT_W   = lpct_pkg::CNT_W;
   localparam int PAGE_W  = lpct_pkg::PAGE_W;
   localparam int STAMP_W = lpct_pkg::STAMP_W;
   localparam int ENTRY_W = lpct_pkg::ENTRY_W;

   lpct_pkg::state_type state_ff, state_in;

   logic [lpct_pkg::CFG_CNT_W-1:0] cfg_cnt_ff;
   logic [PAGE_W-1:0]              cfg_limit_ff;

   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               bad_ff, bad_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic               hit_ff, hit_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic               empty_ff, empty_in;
   logic [IDX_W-1:0]   empty_idx_ff, empty_idx_in;
   logic               min_vld_ff, min_vld_in;
   logic [IDX_W-1:0]   min_idx_ff, min_idx_in;
   logic [STAMP_W-1:0] min_stamp_ff, min_stamp_in;
   logic [PAGE_W-1:0]  min_tag_ff, min_tag_in;
   logic [lpct_pkg::ENTRIES-1:0] valid_ff, valid_in;
   logic [STAMP_W-1:0] stamp_ff, stamp_in;

   logic                         rsp_vld_ff, rsp_vld_in;
   lpct_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [lpct_pkg::SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic                         rsp_ev_vld_ff, rsp_ev_vld_in;
   logic [PAGE_W-1:0]            rsp_ev_page_ff, rsp_ev_page_in;

   logic               accept;
   logic               commit;
   logic               last_read;
   logic [CNT_W-1:0]   cnt_clamp;
   logic               req_bad;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic               ram_we;
   logic [IDX_W-1:0]   victim;
   logic [STAMP_W-1:0] fresh_stamp;
   logic               rd_valid;
   logic [PAGE_W-1:0]  rd_tag;
   logic [STAMP_W-1:0] rd_stamp;

   lpct_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (lpct_pkg::ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (victim),
      .wr_data ({fresh_stamp, page_ff}),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_rd_data)
   );

   assign cnt_clamp = (32'(cfg_cnt_ff) > 32'(lpct_pkg::ENTRIES))
                      ? CNT_W'(lpct_pkg::ENTRIES) : CNT_W'(cfg_cnt_ff);
   assign req_bad   = (req_tdata >= cfg_limit_ff) || (cnt_clamp == '0);
   assign accept    = req_tvalid && req_tready;
   assign commit    = (state_ff == lpct_pkg::ST_DONE) && (!rsp_vld_ff || rsp_tready);
   assign last_read = (CNT_W'(rd_idx_ff) + CNT_W'(1)) == cnt_ff;
   assign ram_we    = commit && !bad_ff;
   assign fresh_stamp = stamp_ff + STAMP_W'(1);

   assign rd_tag   = ram_rd_data[PAGE_W-1:0];
   assign rd_stamp = ram_rd_data[ENTRY_W-1:PAGE_W];
   assign rd_valid = valid_ff[cmp_idx_ff];

   always_comb begin
      if (hit_ff) begin
         victim = hit_idx_ff;
      end else if (empty_ff) begin
         victim = empty_idx_ff;
      end else begin
         victim = min_idx_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lpct_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = req_bad ? lpct_pkg::ST_DONE : lpct_pkg::ST_SCAN;
            end
         end
         lpct_pkg::ST_SCAN: begin
            if (last_read) begin
               state_in = lpct_pkg::ST_LAST;
            end
         end
         lpct_pkg::ST_LAST: begin
            state_in = lpct_pkg::ST_DONE;
         end
         lpct_pkg::ST_DONE: begin
            if (commit) begin
               state_in = lpct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = lpct_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready   = (state_ff == lpct_pkg::ST_IDLE);
      page_in      = page_ff;
      cnt_in       = cnt_ff;
      bad_in       = bad_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = rd_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      empty_in     = empty_ff;
      empty_idx_in = empty_idx_ff;
      min_vld_in   = min_vld_ff;
      min_idx_in   = min_idx_ff;
      min_stamp_in = min_stamp_ff;
      min_tag_in   = min_tag_ff;
      valid_in     = valid_ff;
      stamp_in     = stamp_ff;

      if (accept) begin
         page_in    = req_tdata;
         cnt_in     = cnt_clamp;
         bad_in     = req_bad;
         rd_idx_in  = '0;
         hit_in     = 1'b0;
         empty_in   = 1'b0;
         min_vld_in = 1'b0;
      end

      if (state_ff == lpct_pkg::ST_SCAN) begin
         cmp_vld_in = 1'b1;
         rd_idx_in  = rd_idx_ff + IDX_W'(1);
      end

      if (cmp_vld_ff) begin
         if (rd_valid && (rd_tag == page_ff) && !hit_ff) begin
            hit_in     = 1'b1;
            hit_idx_in = cmp_idx_ff;
         end
         if (!rd_valid && !empty_ff) begin
            empty_in     = 1'b1;
            empty_idx_in = cmp_idx_ff;
         end
         if (rd_valid && (!min_vld_ff || (rd_stamp < min_stamp_ff))) begin
            min_vld_in   = 1'b1;
            min_idx_in   = cmp_idx_ff;
            min_stamp_in = rd_stamp;
            min_tag_in   = rd_tag;
         end
      end

      if (ram_we) begin
         valid_in[victim] = 1'b1;
         stamp_in         = fresh_stamp;
      end

      rsp_vld_in     = commit || (rsp_vld_ff && !rsp_tready);
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_ev_vld_in  = rsp_ev_vld_ff;
      rsp_ev_page_in = rsp_ev_page_ff;
      if (commit) begin
         if (bad_ff) begin
            rsp_status_in  = lpct_pkg::STATUS_BADARG;
            rsp_slot_in    = '0;
            rsp_ev_vld_in  = 1'b0;
            rsp_ev_page_in = '0;
         end else begin
            rsp_status_in  = hit_ff ? lpct_pkg::STATUS_HIT : lpct_pkg::STATUS_MISS;
            rsp_slot_in    = lpct_pkg::SLOT_W'(victim);
            rsp_ev_vld_in  = !hit_ff && !empty_ff;
            rsp_ev_page_in = (!hit_ff && !empty_ff) ? min_tag_ff : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpct_pkg::ST_IDLE;
         cfg_cnt_ff   <= lpct_pkg::CFG_CNT_W'(lpct_pkg::ENTRIES);
         cfg_limit_ff <= '0;
         valid_ff     <= '0;
         stamp_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_vld_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         stamp_ff   <= stamp_in;
         cmp_vld_ff <= cmp_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (csr_we) begin
            unique case (csr_addr)
               lpct_pkg::CSR_ENTRIES_IN_USE: cfg_cnt_ff <= csr_wdata[lpct_pkg::CFG_CNT_W-1:0];
               lpct_pkg::CSR_PAGE_LIMIT:     cfg_limit_ff <= csr_wdata[PAGE_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      page_ff        <= page_in;
      cnt_ff         <= cnt_in;
      bad_ff         <= bad_in;
      rd_idx_ff      <= rd_idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      hit_ff         <= hit_in;
      hit_idx_ff     <= hit_idx_in;
      empty_ff       <= empty_in;
      empty_idx_ff   <= empty_idx_in;
      min_vld_ff     <= min_vld_in;
      min_idx_ff     <= min_idx_in;
      min_stamp_ff   <= min_stamp_in;
      min_tag_ff     <= min_tag_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_ev_vld_ff  <= rsp_ev_vld_in;
      rsp_ev_page_ff <= rsp_ev_page_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = lpct_pkg::RSP_DATA_W'({rsp_ev_page_ff, rsp_ev_vld_ff, rsp_slot_ff,
                                              rsp_status_ff});

   `LPCT_ASSERT_SAME(a_fill_in_range, ram_we, CNT_W'(victim) < cnt_ff)
   `LPCT_ASSERT_NEXT(a_stamp_advance, ram_we, stamp_ff == $past(stamp_ff) + STAMP_W'(1))
   `LPCT_ASSERT_SAME(a_hit_no_evict, commit && hit_ff && !bad_ff, !rsp_ev_vld_in)

endmodule

`default_nettype wire

// File: rtl/lpct_ram.sv
`default_nettype none

module lpct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire
